[src/csa_pkg.sv]
// Shared types, constants and arithmetic helpers for the Cartesian-to-spherical angle pipeline.
package csa_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ROTATION_STEPS  = 16;

    // Coordinates are scaled by 2^GUARD before rotation; four spare bits cover the CORDIC gain.
    localparam int GUARD   = 24;
    localparam int DW      = COORD_WIDTH + GUARD + 4;
    localparam int ACC_W   = 34;
    localparam int ACC_FRAC = 30;
    localparam int KINV_W  = 30;
    localparam int HI_W    = DW - 1 - ACC_FRAC;
    localparam int HIK_W   = DW - 1;
    localparam int LOK_W   = 2 * KINV_W;
    localparam int TAB_IDX_W = 5;

    localparam int POLAR_W = ANGLE_FRAC_BITS + 2;
    localparam int AZIM_W  = ANGLE_FRAC_BITS + 3;
    localparam int RND_SH  = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int RND_W   = ACC_W - RND_SH;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam logic [KINV_W-1:0] KINV_Q30 = 30'd652032874;
    localparam longint PI_OUT = (PI_Q30 + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;

    // Pipeline stage count: pre-rotation, phi rotations, two gain stages,
    // pre-rotation, theta rotations and the output register.
    localparam int NSTG = 2 * ROTATION_STEPS + 5;

    // atan(2^-i) in Q30, truncated.
    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFD, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [DW-1:0]    a;
        logic signed [DW-1:0]    b;
        logic signed [ACC_W-1:0] acc;
    } rot_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] z;
        logic                          zero;
        logic                          axis;
        logic                          last;
        logic signed [AZIM_W-1:0]      phi;
    } side_t;

    // Moves a vector in the left half plane into the right half plane by a quarter turn.
    function automatic rot_t prerot(input logic signed [DW-1:0] a,
                                    input logic signed [DW-1:0] b);
        rot_t r;
        r.a   = a;
        r.b   = b;
        r.acc = '0;
        if (a[DW-1])
        begin
            if (!b[DW-1])
            begin
                r.a   = b;
                r.b   = -a;
                r.acc = ACC_W'(HALF_PI_Q30);
            end
            else
            begin
                r.a   = -b;
                r.b   = a;
                r.acc = -ACC_W'(HALF_PI_Q30);
            end
        end
        return r;
    endfunction

    // One vectoring rotation; idx is a constant at every call site, so the shifts are wiring.
    function automatic rot_t cordic_step(input rot_t r, input logic [TAB_IDX_W-1:0] idx);
        rot_t                    s;
        logic signed [DW-1:0]    da;
        logic signed [DW-1:0]    db;
        logic signed [ACC_W-1:0] ang;
        da  = r.a >>> idx;
        db  = r.b >>> idx;
        ang = ACC_W'(ATAN_TAB[idx]);
        if (!r.b[DW-1])
        begin
            s.a   = r.a + db;
            s.b   = r.b - da;
            s.acc = r.acc + ang;
        end
        else
        begin
            s.a   = r.a - db;
            s.b   = r.b + da;
            s.acc = r.acc - ang;
        end
        return s;
    endfunction

    // Round half up from Q30 to the output scale.
    function automatic logic signed [RND_W-1:0] round_angle(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sum;
        sum = acc + (ACC_W'(1) <<< (RND_SH - 1));
        return RND_W'(sum >>> RND_SH);
    endfunction

endpackage

[src/cartesian_to_spherical_angles_top.sv]
// Top level: pipelined CORDIC conversion of a 3D direction into polar and azimuth angles.
//
// Input channel (in_valid / in_ready) carries one direction word: signed vec_x, vec_y,
// vec_z and the in_last batch mark. Output channel (out_valid / out_ready) returns one
// word per input: polar_angle (0..pi, unsigned Q2.13) and azimuth_angle (-pi..pi, signed Q3.13) in radians,
// zero_vector and out_last, in input order.
// The work runs through 2*ROTATION_STEPS+5 register stages (37 by default): a quarter
// turn and one rotation per stage for the azimuth, two stages that multiply out the
// CORDIC gain, then a quarter turn and one rotation per stage for the polar angle, and
// the output register. One word is accepted every cycle while in_ready is high, that is
// while the receiver keeps up or a stage is empty; the rotation chain is fully unrolled.
// Reset clears every stage valid bit, so the pipeline comes up empty and ready.
// When the receiver stalls, the output word holds and each stage holds only while
// every stage after it is full, so in_ready stays high until the pipeline has no
// empty slot left; bubbles are squeezed out and no word is lost or repeated.
// A zero vector gives zero angles with zero_vector set; a vector on the z axis gives
// azimuth 0 and polar 0 or pi by the sign of z.
module cartesian_to_spherical_angles_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [csa_pkg::COORD_WIDTH-1:0] vec_x,
    input  logic signed [csa_pkg::COORD_WIDTH-1:0] vec_y,
    input  logic signed [csa_pkg::COORD_WIDTH-1:0] vec_z,
    input  logic                                  in_last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic        [csa_pkg::POLAR_W-1:0]     polar_angle,
    output logic signed [csa_pkg::AZIM_W-1:0]      azimuth_angle,
    output logic                                  zero_vector,
    output logic                                  out_last
);
    import csa_pkg::*;

    localparam int N     = ROTATION_STEPS;
    localparam int ST_G1 = N + 1;
    localparam int ST_G2 = N + 2;
    localparam int ST_T0 = N + 3;
    localparam int ST_OUT = NSTG - 1;
    localparam logic signed [RND_W-1:0] PI_R = RND_W'(PI_OUT);

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] ld;

    rot_t  phi_reg   [0:N];
    rot_t  theta_reg [0:N];
    side_t side_reg  [0:ST_OUT-1];

    logic [HIK_W-1:0]     hik_reg;
    logic [LOK_W-1:0]     lok_reg;
    logic signed [DW-1:0] rho_reg;

    logic [POLAR_W-1:0]       polar_reg;
    logic signed [AZIM_W-1:0] azim_reg;
    logic                     zero_reg;
    logic                     last_reg;

    // Stage i may load when any stage from i onward is empty or the output is taken.
    always_comb
    begin
        for (int i = 0; i < NSTG; i++)
        begin
            ld[i] = out_ready || (((~v_reg) >> i) != '0);
        end
    end

    assign in_ready = ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (ld[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Input stage: scale and quarter-turn (x, y), record the special cases.
    logic signed [DW-1:0] xg;
    logic signed [DW-1:0] yg;
    side_t                side_in;

    assign xg = DW'(vec_x) <<< GUARD;
    assign yg = DW'(vec_y) <<< GUARD;

    always_comb
    begin
        side_in.z    = vec_z;
        side_in.axis = (vec_x == '0) && (vec_y == '0);
        side_in.zero = side_in.axis && (vec_z == '0);
        side_in.last = in_last;
        side_in.phi  = '0;
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            phi_reg[0]  <= prerot(xg, yg);
            side_reg[0] <= side_in;
        end
    end

    // Azimuth rotations, one per stage.
    for (genvar k = 1; k <= N; k++)
    begin : g_phi
        always_ff @(posedge clk)
        begin
            if (ld[k])
            begin
                phi_reg[k]  <= cordic_step(phi_reg[k-1], TAB_IDX_W'(k - 1));
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Gain stage one: split the magnitude and multiply both halves by 1/K; round and clamp the azimuth.
    logic [DW-2:0]            mag_c;
    logic [HI_W-1:0]          mag_hi;
    logic [ACC_FRAC-1:0]      mag_lo;
    logic signed [RND_W-1:0]  phi_r;
    side_t                    side_g1;

    always_comb
    begin
        mag_c  = phi_reg[N].a[DW-1] ? '0 : phi_reg[N].a[DW-2:0];
        mag_hi = mag_c[DW-2:ACC_FRAC];
        mag_lo = mag_c[ACC_FRAC-1:0];
        phi_r  = round_angle(phi_reg[N].acc);
        side_g1 = side_reg[N];
        if (phi_r < -PI_R)
        begin
            side_g1.phi = AZIM_W'(-PI_R);
        end
        else if (phi_r > PI_R)
        begin
            side_g1.phi = AZIM_W'(PI_R);
        end
        else
        begin
            side_g1.phi = AZIM_W'(phi_r);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[ST_G1])
        begin
            hik_reg         <= HIK_W'(mag_hi) * HIK_W'(KINV_Q30);
            lok_reg         <= LOK_W'(mag_lo) * LOK_W'(KINV_Q30);
            side_reg[ST_G1] <= side_g1;
        end
    end

    // Gain stage two: join the partial products with rounding into rho.
    logic [LOK_W-1:0] lok_rnd;
    logic [DW-1:0]    rho_next;

    assign lok_rnd  = lok_reg + (LOK_W'(1) << (ACC_FRAC - 1));
    assign rho_next = DW'(hik_reg) + DW'(lok_rnd >> ACC_FRAC);

    always_ff @(posedge clk)
    begin
        if (ld[ST_G2])
        begin
            rho_reg         <= signed'(rho_next);
            side_reg[ST_G2] <= side_reg[ST_G1];
        end
    end

    // Polar stages: quarter-turn (z, rho), then one rotation per stage.
    logic signed [DW-1:0] zg;
    assign zg = DW'(side_reg[ST_G2].z) <<< GUARD;

    always_ff @(posedge clk)
    begin
        if (ld[ST_T0])
        begin
            theta_reg[0]    <= prerot(zg, rho_reg);
            side_reg[ST_T0] <= side_reg[ST_G2];
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_theta
        always_ff @(posedge clk)
        begin
            if (ld[ST_T0 + k])
            begin
                theta_reg[k]        <= cordic_step(theta_reg[k-1], TAB_IDX_W'(k - 1));
                side_reg[ST_T0 + k] <= side_reg[ST_T0 + k - 1];
            end
        end
    end

    // Output stage: round and clamp the polar angle, apply the special cases.
    side_t                    side_t_n;
    logic signed [RND_W-1:0]  theta_r;
    logic [POLAR_W-1:0]       polar_next;
    logic signed [AZIM_W-1:0] azim_next;

    always_comb
    begin
        side_t_n = side_reg[ST_OUT-1];
        theta_r  = round_angle(theta_reg[N].acc);
        if (side_t_n.zero)
        begin
            polar_next = '0;
            azim_next  = '0;
        end
        else if (side_t_n.axis)
        begin
            azim_next = '0;
            if (!side_t_n.z[COORD_WIDTH-1])
            begin
                polar_next = '0;
            end
            else
            begin
                polar_next = POLAR_W'(PI_R);
            end
        end
        else
        begin
            azim_next = side_t_n.phi;
            if (theta_r[RND_W-1])
            begin
                polar_next = '0;
            end
            else if (theta_r > PI_R)
            begin
                polar_next = POLAR_W'(PI_R);
            end
            else
            begin
                polar_next = POLAR_W'(theta_r);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[ST_OUT])
        begin
            polar_reg <= polar_next;
            azim_reg  <= azim_next;
            zero_reg  <= side_t_n.zero;
            last_reg  <= side_t_n.last;
        end
    end

    assign out_valid     = v_reg[ST_OUT];
    assign polar_angle   = polar_reg;
    assign azimuth_angle = azim_reg;
    assign zero_vector   = zero_reg;
    assign out_last      = last_reg;

    // A zero vector must come out with both angles zero.
    a_zero_angles: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_vector |-> polar_angle == '0 && azimuth_angle == '0)
        else $error("zero vector word carries nonzero angles");

    // The polar angle never leaves [0, pi].
    a_polar_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> polar_angle <= POLAR_W'(PI_R))
        else $error("polar angle above pi");

    // The azimuth never leaves [-pi, pi].
    a_azim_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> azimuth_angle <= AZIM_W'(PI_R) && azimuth_angle >= -AZIM_W'(PI_R))
        else $error("azimuth outside [-pi, pi]");

    // An empty first stage must always accept a word.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> in_ready)
        else $error("input stalled while the first stage is empty");

    // A word taken at the input, whether or not the output is stalled, must land in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted word missing from the first stage");

endmodule
